[rtl/core/faf_pkg.sv]
// Shared types and constants of the forward ant admission filter.
// Used by faf_cell and by the top level; depends on nothing.
`default_nettype none

package faf_pkg;

  localparam int unsigned AddrW    = 32;
  localparam int unsigned GenW     = 32;
  localparam int unsigned HopW     = 8;
  localparam int unsigned TimeW    = 32;
  localparam int unsigned TypeW    = 8;
  localparam int unsigned RatioW   = 16;
  localparam int unsigned FracW    = 8;
  localparam int unsigned InDataW  = AddrW + GenW + HopW + TimeW;
  localparam int unsigned OutDataW = 8;
  localparam int unsigned CfgIdxW  = 1;

  localparam logic [CfgIdxW-1:0] CFG_RATIO = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_TYPE  = 1'b1;

  localparam logic [RatioW-1:0] RATIO_RESET = 16'd384;
  localparam logic [TypeW-1:0]  TYPE_RESET  = 8'd0;

  // Search token moving down the chain, with the entry it picked up.
  typedef struct packed {
    logic             vld;
    logic             found;
    logic             hit;
    logic [AddrW-1:0] src;
    logic [GenW-1:0]  gen;
    logic [HopW-1:0]  hops;
    logic [TimeW-1:0] tm;
  } probe_t;

  // Write-back broadcast to the cell that owns the current item.
  typedef struct packed {
    logic             fire;
    logic             we;
    logic [AddrW-1:0] src;
    logic [GenW-1:0]  gen;
    logic [HopW-1:0]  hops;
    logic [TimeW-1:0] tm;
  } wback_t;

endpackage

`default_nettype wire

[rtl/core/faf_cell.sv]
// One table entry of the admission filter with its stage of the search chain.
// Depends on faf_pkg for the probe and write-back types.
`default_nettype none

module faf_cell
  import faf_pkg::*;
(
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire probe_t probe_i,
  input  wire wback_t wb_i,
  output probe_t      probe_o,
  output logic        valid_o,
  output logic        owner_o
);

  logic             valid_q;
  logic             owner_q;
  logic [AddrW-1:0] src_q;
  logic [GenW-1:0]  gen_q;
  logic [HopW-1:0]  hops_q;
  logic [TimeW-1:0] tm_q;
  probe_t           probe_q;
  probe_t           probe_d;
  logic             match;
  logic             take;

  assign match = valid_q && (src_q == probe_i.src);
  assign take  = probe_i.vld && !probe_i.found && (match || !valid_q);

  always_comb begin
    probe_d = probe_i;
    if (take) begin
      probe_d.found = 1'b1;
      probe_d.hit   = match;
      probe_d.gen   = gen_q;
      probe_d.hops  = hops_q;
      probe_d.tm    = tm_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      owner_q <= 1'b0;
      probe_q <= '0;
    end else begin
      probe_q <= probe_d;
      if (take) begin
        owner_q <= 1'b1;
      end else if (wb_i.fire) begin
        owner_q <= 1'b0;
      end
      if (wb_i.fire && wb_i.we && owner_q) begin
        valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wb_i.fire && wb_i.we && owner_q) begin
      src_q  <= wb_i.src;
      gen_q  <= wb_i.gen;
      hops_q <= wb_i.hops;
      tm_q   <= wb_i.tm;
    end
  end

  assign probe_o = probe_q;
  assign valid_o = valid_q;
  assign owner_o = owner_q;

endmodule

`default_nettype wire

[rtl/core/forward_ant_admission_filter_top.sv]
// Top level of the forward ant admission filter: search chain, decision and ports.
// Depends on faf_pkg and instantiates faf_cell once per table entry.
//
//   channel  direction  fields
//   s_axis   in         tuser: packet_type; tdata: source, generation, hops, time
//   m_axis   out        tdata: admitted, new_source, table_full
//   cfg      in         write enable, register index, write data
//
// An item of the accepted type goes from acceptance to result in these steps: the
// search token walks the cell chain one cell a cycle, the first cell in the
// accepting cycle, then the multiply step and the decision step.
// An item of the wrong type skips the walk and goes straight to the decision step.
// One item is in flight at a time; reset empties the table at once.
// A held result stalls the decision step until the output register drains.
`default_nettype none

module forward_ant_admission_filter_top
  import faf_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = 64
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  // [31:0] source_address, [63:32] generation, [71:64] hop_count,
  // [103:72] time_estimate
  input  wire logic [InDataW-1:0]  s_axis_tdata,
  // [7:0] packet_type
  input  wire logic [TypeW-1:0]    s_axis_tuser,
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  // [0] admitted, [1] new_source, [2] table_full, [7:3] zero
  output logic [OutDataW-1:0]      m_axis_tdata,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [RatioW-1:0]   cfg_wdata_i
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_WALK = 2'd1;
  localparam logic [1:0] S_DEC  = 2'd2;

  localparam int unsigned HopBW = RatioW - FracW + HopW + 1;
  localparam int unsigned ProdW = RatioW + TimeW;

  logic [1:0]         state_q;
  logic [RatioW-1:0]  ratio_q;
  logic [TypeW-1:0]   type_q;
  logic [AddrW-1:0]   src_q;
  logic [GenW-1:0]    gen_q;
  logic [HopW-1:0]    hop_q;
  logic [TimeW-1:0]   tm_q;
  logic               bad_q;
  logic               found_q;
  logic               hit_q;
  logic               gen_gt_q;
  logic               gen_eq_q;
  logic               hop_ok_q;
  logic [HopW-1:0]    best_hops_q;
  logic               tbz_q;
  logic [ProdW-1:0]   prod_q;
  logic               out_vld_q;
  logic [2:0]         out_q;

  logic               accept;
  logic               type_ok;
  logic               out_free;
  logic [HopBW-1:0]   hop_bound;
  logic               hop_ok;
  logic               time_ok;
  logic               adm;
  logic               fresh;
  logic               full;
  logic               we;
  probe_t             head;
  probe_t             tail;
  wback_t             wb;
  probe_t             link [0:TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] valid_vec;
  logic [TABLE_ENTRIES-1:0] owner_vec;

  assign s_axis_tready = (state_q == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign type_ok       = (s_axis_tuser == type_q);
  assign out_free      = !out_vld_q || m_axis_tready;

  always_comb begin
    head       = '0;
    head.vld   = accept && type_ok;
    head.src   = s_axis_tdata[AddrW-1:0];
  end

  assign link[0] = head;
  assign tail    = link[TABLE_ENTRIES];

  for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
    faf_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .probe_i (link[g]),
      .wb_i    (wb),
      .probe_o (link[g+1]),
      .valid_o (valid_vec[g]),
      .owner_o (owner_vec[g])
    );
  end

  // Hop test: floor(hop / best) <= ratio integer part  <=>  hop < (int + 1) * best.
  assign hop_bound = HopBW'(ratio_q[RatioW-1:FracW]) * HopBW'(tail.hops)
                   + HopBW'(tail.hops);
  assign hop_ok    = (tail.hops == '0) ? (hop_q == '0) : (HopBW'(hop_q) < hop_bound);

  assign time_ok = tbz_q ? (tm_q == '0)
                         : (ProdW'({tm_q, {FracW{1'b0}}}) <= prod_q);

  always_comb begin
    adm   = 1'b0;
    fresh = 1'b0;
    full  = 1'b0;
    we    = 1'b0;
    if (!bad_q) begin
      if (!found_q) begin
        full = 1'b1;
      end else if (!hit_q) begin
        adm   = 1'b1;
        fresh = 1'b1;
        we    = 1'b1;
      end else if (gen_gt_q) begin
        adm = 1'b1;
        we  = 1'b1;
      end else if (gen_eq_q) begin
        adm = hop_ok_q && time_ok;
        we  = adm && ((hop_q >= best_hops_q) || (tm_q != '0));
      end
    end
  end

  always_comb begin
    wb      = '0;
    wb.fire = (state_q == S_DEC) && out_free;
    wb.we   = we;
    wb.src  = src_q;
    wb.gen  = gen_q;
    wb.hops = hop_q;
    wb.tm   = tm_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      ratio_q   <= RATIO_RESET;
      type_q    <= TYPE_RESET;
      out_vld_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_RATIO: ratio_q <= cfg_wdata_i;
          CFG_TYPE:  type_q  <= cfg_wdata_i[TypeW-1:0];
          default:   ;
        endcase
      end
      if (wb.fire) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            state_q <= type_ok ? S_WALK : S_DEC;
          end
        end
        S_WALK: begin
          if (tail.vld) begin
            state_q <= S_DEC;
          end
        end
        S_DEC: begin
          if (out_free) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      bad_q <= !type_ok;
      src_q <= s_axis_tdata[AddrW-1:0];
      gen_q <= s_axis_tdata[AddrW+GenW-1:AddrW];
      hop_q <= s_axis_tdata[AddrW+GenW+HopW-1:AddrW+GenW];
      tm_q  <= s_axis_tdata[InDataW-1:AddrW+GenW+HopW];
    end
    if ((state_q == S_WALK) && tail.vld) begin
      found_q     <= tail.found;
      hit_q       <= tail.hit;
      gen_gt_q    <= gen_q > tail.gen;
      gen_eq_q    <= gen_q == tail.gen;
      hop_ok_q    <= hop_ok;
      best_hops_q <= tail.hops;
      tbz_q       <= (tail.tm == '0);
      prod_q      <= ProdW'(ratio_q) * ProdW'(tail.tm);
    end
    if (wb.fire) begin
      out_q <= {full, fresh, adm};
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {{(OutDataW-3){1'b0}}, out_q};

  a_tail_in_walk : assert property (@(posedge clk_i) disable iff (!rst_ni)
    tail.vld |-> (state_q == S_WALK))
    else $error("search token left the chain outside the walk");

  a_valid_prefix : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot({1'b0, valid_vec} + (TABLE_ENTRIES+1)'(1)))
    else $error("occupied entries do not form a prefix");

  a_one_owner : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(owner_vec))
    else $error("more than one cell owns the item");

  a_fresh_grows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wb.fire && fresh) |=> ($countones(valid_vec) == $past($countones(valid_vec)) + 1))
    else $error("new source did not occupy exactly one entry");

  a_result_flags : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tdata[0] && m_axis_tdata[2]))
    else $error("item both admitted and rejected as table full");

endmodule

`default_nettype wire
